// ===== hw/rtl/nlms_pkg.sv =====
// ----------------------------------------------------------------------------
// nlms_pkg
// Shared sizes, codes and types of the multichannel path identifier.
// ----------------------------------------------------------------------------
package nlms_pkg;

  localparam int TAPS     = 64;
  localparam int SPEAKERS = 4;
  localparam int MICS     = 4;
  localparam int NPORT    = 4;

  localparam int NHIST    = SPEAKERS * TAPS;
  localparam int NCOEF    = MICS * SPEAKERS * TAPS;
  localparam int TAP_W    = $clog2(TAPS);
  localparam int HADDR_W  = $clog2(NHIST);
  localparam int CADDR_W  = $clog2(NCOEF);
  localparam int SPK_W    = (SPEAKERS > 1) ? $clog2(SPEAKERS) : 1;
  localparam int MIC_W    = (MICS > 1) ? $clog2(MICS) : 1;

  localparam int SAMP_W   = 16;
  localparam int COEF_W   = 24;
  localparam int IDX_W    = 10;
  localparam int GAIN_W   = 32;
  localparam int STEP_W   = 32;
  localparam int FLOOR_W  = 31;
  localparam int CNT_W    = 3;
  localparam int CFG_W    = 32;
  localparam int DIVD_W   = STEP_W + 22;
  // power: floor plus TAPS squares of up to 2^30 each
  localparam int P_W      = 32 + $clog2(TAPS + 1);
  // prediction accumulator: 40 bit products over every speaker tap plus margin
  localparam int ACC_W    = SAMP_W + COEF_W + $clog2(NHIST) + 2;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_STEP     = 2'd0,
    REG_FLOOR    = 2'd1,
    REG_SPEAKERS = 2'd2,
    REG_MICS     = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] gain;
  } div_result_t;

endpackage

// ===== hw/rtl/nlms_ram.sv =====
// ----------------------------------------------------------------------------
// nlms_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nlms_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/nlms_div.sv =====
// ----------------------------------------------------------------------------
// nlms_div
// Restoring divider for the step gain, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nlms_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [nlms_pkg::DIVD_W-1:0] dividend,
  input  logic [nlms_pkg::P_W-1:0]    divisor,
  output nlms_pkg::div_result_t     result
);
  import nlms_pkg::*;

  localparam int DC_W = $clog2(DIVD_W + 1);

  logic [P_W-1:0]    rem;
  logic [P_W-1:0]    dvs;
  logic [DIVD_W-1:0] quo;
  logic [DC_W-1:0]   cnt;
  logic              busy;
  logic              done;
  logic [P_W:0]      trial;
  logic              ge;

  // one restoring step
  always_comb begin
    trial = {rem, quo[DIVD_W-1]};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        dvs  <= divisor;
        quo  <= dividend;
        cnt  <= '0;
      end else if (busy) begin
        rem <= ge ? P_W'(trial - {1'b0, dvs}) : trial[P_W-1:0];
        quo <= {quo[DIVD_W-2:0], ge};
        if (cnt == DC_W'(DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // saturate the quotient to the gain width
  assign result.done = done;
  assign result.gain = (|quo[DIVD_W-1:GAIN_W]) ? '1 : quo[GAIN_W-1:0];

endmodule

// ===== hw/rtl/multichannel_nlms_path_identifier_unit.sv =====
// ----------------------------------------------------------------------------
// multichannel_nlms_path_identifier_unit
// Multichannel NLMS identification of the speaker to microphone paths.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready) carries one item: a sample and adapt item,
//   a coefficient write or a coefficient read. out channel (out_valid/
//   out_ready) returns one result per item. cfg_we/cfg_index/cfg_data write
//   the step, the power floor and the active speaker and mic counts; the
//   user must write them only while the block is idle, which the block
//   itself does not enforce. Items are taken one at a time. A sample item
//   runs from one sequencer over the history and coefficient memories, one
//   access per cycle: ns history writes, then per speaker a sum of squares
//   and a divide, then per mic a prediction and an update. After reset a
//   clearing pass zeroes both memories, with in_ready low. A finished
//   result waits in the output register; the next item may be taken
//   meanwhile, and its own result waits until the receiver has taken the
//   previous one.
// ----------------------------------------------------------------------------
module multichannel_nlms_path_identifier_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [nlms_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        kind,
  input  logic signed [nlms_pkg::SAMP_W-1:0] anti_0,
  input  logic signed [nlms_pkg::SAMP_W-1:0] anti_1,
  input  logic signed [nlms_pkg::SAMP_W-1:0] anti_2,
  input  logic signed [nlms_pkg::SAMP_W-1:0] anti_3,
  input  logic signed [nlms_pkg::SAMP_W-1:0] err_0,
  input  logic signed [nlms_pkg::SAMP_W-1:0] err_1,
  input  logic signed [nlms_pkg::SAMP_W-1:0] err_2,
  input  logic signed [nlms_pkg::SAMP_W-1:0] err_3,
  input  logic [nlms_pkg::IDX_W-1:0]        coef_index,
  input  logic signed [nlms_pkg::COEF_W-1:0] coef_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [nlms_pkg::SAMP_W-1:0] id_err_0,
  output logic signed [nlms_pkg::SAMP_W-1:0] id_err_1,
  output logic signed [nlms_pkg::SAMP_W-1:0] id_err_2,
  output logic signed [nlms_pkg::SAMP_W-1:0] id_err_3,
  output logic signed [nlms_pkg::COEF_W-1:0] coef_read
);
  import nlms_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HWR, ST_PWR, ST_DIV, ST_PRED, ST_EQ, ST_UPD,
    ST_CWR, ST_CRD, ST_CRD2, ST_DONE
  } state_t;

  localparam int CLR_W = CADDR_W + 1;

  // configuration registers
  logic [STEP_W-1:0]  step_size;
  logic [FLOOR_W-1:0] pwr_floor;
  logic [CNT_W-1:0]   active_speakers;
  logic [CNT_W-1:0]   active_mics;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size       <= '0;
      pwr_floor       <= FLOOR_W'(1074);
      active_speakers <= CNT_W'(4);
      active_mics     <= CNT_W'(4);
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_STEP:     step_size       <= cfg_data[STEP_W-1:0];
        REG_FLOOR:    pwr_floor       <= cfg_data[FLOOR_W-1:0];
        REG_SPEAKERS: active_speakers <= cfg_data[CNT_W-1:0];
        REG_MICS:     active_mics     <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped channel counts
  logic [CNT_W-1:0] ns;
  logic [CNT_W-1:0] nm;
  logic [SPK_W-1:0] ns_m1;
  logic [MIC_W-1:0] nm_m1;

  always_comb begin
    if (active_speakers == '0) ns = CNT_W'(1);
    else if (active_speakers > CNT_W'(SPEAKERS)) ns = CNT_W'(SPEAKERS);
    else ns = active_speakers;
    if (active_mics == '0) nm = CNT_W'(1);
    else if (active_mics > CNT_W'(MICS)) nm = CNT_W'(MICS);
    else nm = active_mics;
    ns_m1 = SPK_W'(ns - CNT_W'(1));
    nm_m1 = MIC_W'(nm - CNT_W'(1));
  end

  // port bundles
  logic signed [SAMP_W-1:0] anti_in [NPORT];
  logic signed [SAMP_W-1:0] err_in  [NPORT];
  assign anti_in[0] = anti_0;
  assign anti_in[1] = anti_1;
  assign anti_in[2] = anti_2;
  assign anti_in[3] = anti_3;
  assign err_in[0]  = err_0;
  assign err_in[1]  = err_1;
  assign err_in[2]  = err_2;
  assign err_in[3]  = err_3;

  // sequencer state
  state_t                  state;
  logic [CLR_W-1:0]        clr_cnt;
  logic signed [SAMP_W-1:0] it_anti [SPEAKERS];
  logic signed [SAMP_W-1:0] it_err  [MICS];
  logic [IDX_W-1:0]        it_idx;
  logic signed [COEF_W-1:0] it_val;
  logic [TAP_W-1:0]        ptr;
  logic [TAP_W-1:0]        newest;
  logic [SPK_W-1:0]        s_cnt;
  logic [MIC_W-1:0]        e_cnt;
  logic [TAP_W-1:0]        k_cnt;
  logic [TAP_W-1:0]        hidx;
  logic                    iss_on;
  logic                    r1_v;
  logic [CADDR_W-1:0]      r1_addr;
  logic [SPK_W-1:0]        r1_s;
  logic                    r2_v;
  logic signed [2*SAMP_W-1:0] r2_eh;
  logic signed [COEF_W-1:0] r2_c;
  logic [CADDR_W-1:0]      r2_addr;
  logic [GAIN_W-1:0]       r2_g;
  logic                    r3_v;
  logic signed [2*SAMP_W+GAIN_W:0] r3_p;
  logic signed [COEF_W-1:0] r3_c;
  logic [CADDR_W-1:0]      r3_addr;
  logic [P_W-1:0]          pacc;
  logic signed [ACC_W-1:0] acc;
  logic signed [SAMP_W-1:0] eq;
  logic [GAIN_W-1:0]       gain [SPEAKERS];
  logic signed [SAMP_W-1:0] res_err [NPORT];
  logic signed [COEF_W-1:0] res_coef;
  logic signed [SAMP_W-1:0] out_err [NPORT];
  logic                    div_start;

  // memory ports
  logic                    h_we;
  logic [HADDR_W-1:0]      h_waddr;
  logic [SAMP_W-1:0]       h_wdata;
  logic [HADDR_W-1:0]      h_raddr;
  logic [SAMP_W-1:0]       h_rdata;
  logic                    c_we;
  logic [CADDR_W-1:0]      c_waddr;
  logic [COEF_W-1:0]       c_wdata;
  logic [CADDR_W-1:0]      c_raddr;
  logic [COEF_W-1:0]       c_rdata;

  nlms_ram #(.DEPTH(NHIST), .WIDTH(SAMP_W)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  nlms_ram #(.DEPTH(NCOEF), .WIDTH(COEF_W)) u_coef (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  // gain divider
  logic [P_W-1:0] pwr_sum;
  logic [P_W-1:0] pwr_div;
  div_result_t    div_res;

  always_comb begin
    pwr_sum = pacc + P_W'(pwr_floor);
    pwr_div = (pwr_sum == '0) ? P_W'(1) : pwr_sum;
  end

  nlms_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({step_size, 22'd0}), .divisor(pwr_div), .result(div_res)
  );

  // datapath arithmetic
  logic signed [SAMP_W-1:0]   h_s;
  logic signed [COEF_W-1:0]   c_s;
  logic signed [2*SAMP_W-1:0] sq;
  logic signed [SAMP_W+COEF_W-1:0] cp;
  logic signed [ACC_W-1:0]    full;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [SAMP_W-1:0]   eq_next;
  logic signed [2*SAMP_W+GAIN_W:0] dsum;
  logic signed [2*SAMP_W+2:0] dlt;
  logic signed [2*SAMP_W+3:0] cnew;
  logic signed [COEF_W-1:0]   c_sat;
  logic                       coef_ok;

  always_comb begin
    h_s  = signed'(h_rdata);
    c_s  = signed'(c_rdata);
    sq   = h_s * h_s;
    cp   = c_s * h_s;
    full = (ACC_W'(it_err[e_cnt]) <<< 22) - acc;
    rnd  = (full + ACC_W'(2097152)) >>> 22;
    if (rnd < -ACC_W'(32768)) eq_next = -16'sd32768;
    else if (rnd > ACC_W'(32767)) eq_next = 16'sd32767;
    else eq_next = SAMP_W'(rnd);
    dsum = r3_p + (2*SAMP_W+GAIN_W+1)'(64'sd2147483648);
    dlt  = (2*SAMP_W+3)'(dsum >>> 32);
    cnew = (2*SAMP_W+4)'(r3_c) + (2*SAMP_W+4)'(dlt);
    if (cnew < -(2*SAMP_W+4)'(8388608)) c_sat = -24'sd8388608;
    else if (cnew > (2*SAMP_W+4)'(8388607)) c_sat = 24'sd8388607;
    else c_sat = COEF_W'(cnew);
    coef_ok = ({1'b0, it_idx} < (IDX_W+1)'(NCOEF));
  end

  // memory address and write selection
  always_comb begin
    h_we    = 1'b0;
    h_waddr = HADDR_W'(int'(s_cnt) * TAPS + int'(ptr));
    h_wdata = it_anti[s_cnt];
    h_raddr = HADDR_W'(int'(s_cnt) * TAPS + int'(hidx));
    c_we    = 1'b0;
    c_waddr = r3_addr;
    c_wdata = c_sat;
    c_raddr = CADDR_W'((int'(e_cnt) * SPEAKERS + int'(s_cnt)) * TAPS + int'(k_cnt));
    case (state)
      ST_CLEAR: begin
        h_we    = (clr_cnt < CLR_W'(NHIST));
        h_waddr = clr_cnt[HADDR_W-1:0];
        h_wdata = '0;
        c_we    = 1'b1;
        c_waddr = clr_cnt[CADDR_W-1:0];
        c_wdata = '0;
      end
      ST_HWR: h_we = 1'b1;
      ST_PWR: h_raddr = HADDR_W'(int'(s_cnt) * TAPS + int'(k_cnt));
      ST_UPD: c_we = r3_v;
      ST_CWR: begin
        c_we    = coef_ok;
        c_waddr = CADDR_W'(it_idx);
        c_wdata = it_val;
      end
      ST_CRD: c_raddr = CADDR_W'(it_idx);
      default: ;
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      ptr       <= '0;
      iss_on    <= 1'b0;
      r1_v      <= 1'b0;
      r2_v      <= 1'b0;
      r3_v      <= 1'b0;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // divide starts once the power sum has settled
      div_start <= (state == ST_PWR) && !iss_on && !r1_v;

      // output register: load a finished result, clear on transfer
      if (state == ST_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      // update pipeline, advances every cycle
      r2_v    <= r1_v && (state == ST_UPD);
      r2_eh   <= eq * h_s;
      r2_c    <= c_s;
      r2_addr <= r1_addr;
      r2_g    <= gain[r1_s];
      r3_v    <= r2_v;
      r3_p    <= r2_eh * signed'({1'b0, r2_g});
      r3_c    <= r2_c;
      r3_addr <= r2_addr;
      r1_addr <= c_raddr;
      r1_s    <= s_cnt;

      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_W'(NCOEF - 1)) state <= ST_IDLE;
        end

        ST_IDLE: begin
          if (in_valid) begin
            for (int i = 0; i < SPEAKERS; i++) it_anti[i] <= anti_in[i];
            for (int i = 0; i < MICS; i++) it_err[i] <= err_in[i];
            it_idx   <= coef_index;
            it_val   <= coef_value;
            for (int i = 0; i < NPORT; i++) res_err[i] <= '0;
            res_coef <= '0;
            s_cnt    <= '0;
            e_cnt    <= '0;
            case (kind_t'(kind))
              KIND_SAMPLE: state <= ST_HWR;
              KIND_WRITE:  state <= ST_CWR;
              KIND_READ:   state <= ST_CRD;
              default:     state <= ST_DONE;
            endcase
          end
        end

        // push the new drive samples
        ST_HWR: begin
          if (s_cnt == ns_m1) begin
            newest <= ptr;
            ptr    <= (ptr == TAP_W'(TAPS - 1)) ? '0 : ptr + 1'b1;
            s_cnt  <= '0;
            k_cnt  <= '0;
            pacc   <= '0;
            iss_on <= 1'b1;
            state  <= ST_PWR;
          end else begin
            s_cnt <= s_cnt + 1'b1;
          end
        end

        // sum of squares over one delay line
        ST_PWR: begin
          r1_v <= iss_on;
          if (iss_on) begin
            k_cnt <= k_cnt + 1'b1;
            if (k_cnt == TAP_W'(TAPS - 1)) iss_on <= 1'b0;
          end
          if (r1_v) pacc <= pacc + P_W'(unsigned'(sq));
          if (!iss_on && !r1_v) state <= ST_DIV;
        end

        ST_DIV: begin
          if (div_res.done) begin
            gain[s_cnt] <= div_res.gain;
            k_cnt  <= '0;
            iss_on <= 1'b1;
            if (s_cnt == ns_m1) begin
              s_cnt <= '0;
              hidx  <= newest;
              acc   <= '0;
              state <= ST_PRED;
            end else begin
              s_cnt <= s_cnt + 1'b1;
              pacc  <= '0;
              state <= ST_PWR;
            end
          end
        end

        // prediction for one mic, then the per-tap update
        ST_PRED, ST_UPD: begin
          r1_v <= iss_on;
          if (iss_on) begin
            if (k_cnt == TAP_W'(TAPS - 1)) begin
              k_cnt <= '0;
              hidx  <= newest;
              if (s_cnt == ns_m1) iss_on <= 1'b0;
              else s_cnt <= s_cnt + 1'b1;
            end else begin
              k_cnt <= k_cnt + 1'b1;
              hidx  <= (hidx == '0) ? TAP_W'(TAPS - 1) : hidx - 1'b1;
            end
          end
          if (state == ST_PRED) begin
            if (r1_v) acc <= acc + ACC_W'(cp);
            if (!iss_on && !r1_v) state <= ST_EQ;
          end else if (!iss_on && !r1_v && !r2_v && !r3_v) begin
            if (e_cnt == nm_m1) begin
              state <= ST_DONE;
            end else begin
              e_cnt  <= e_cnt + 1'b1;
              s_cnt  <= '0;
              k_cnt  <= '0;
              hidx   <= newest;
              acc    <= '0;
              iss_on <= 1'b1;
              state  <= ST_PRED;
            end
          end
        end

        ST_EQ: begin
          eq             <= eq_next;
          res_err[e_cnt] <= eq_next;
          s_cnt          <= '0;
          k_cnt          <= '0;
          hidx           <= newest;
          iss_on         <= 1'b1;
          state          <= ST_UPD;
        end

        ST_CWR: state <= ST_DONE;
        ST_CRD: state <= ST_CRD2;

        ST_CRD2: begin
          res_coef <= coef_ok ? c_s : '0;
          state    <= ST_DONE;
        end

        // hand the result to the output register
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            for (int i = 0; i < NPORT; i++) out_err[i] <= res_err[i];
            coef_read <= res_coef;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign id_err_0 = out_err[0];
  assign id_err_1 = out_err[1];
  assign id_err_2 = out_err[2];
  assign id_err_3 = out_err[3];

endmodule

// ===== hw/rtl/nlms_checker.sv =====
// ----------------------------------------------------------------------------
// nlms_checker
// Port-level checks of the path identifier, bound to the top level.
// ----------------------------------------------------------------------------
module nlms_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] id_err_0,
  input logic [15:0] id_err_1,
  input logic [15:0] id_err_2,
  input logic [15:0] id_err_3,
  input logic [23:0] coef_read
);

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // clearing pass keeps the input closed right after reset
  a_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input open during clearing pass");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // a read result carries no identification error
  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (coef_read == 24'd0) ||
      (id_err_0 == 16'd0 && id_err_1 == 16'd0 && id_err_2 == 16'd0 && id_err_3 == 16'd0))
    else $error("mixed result fields");

endmodule

bind multichannel_nlms_path_identifier_unit nlms_checker u_nlms_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .id_err_0(id_err_0),
  .id_err_1(id_err_1), .id_err_2(id_err_2), .id_err_3(id_err_3),
  .coef_read(coef_read)
);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the multichannel NLMS path identifier against a cycle-free predictor
// of its sample, adapt, coefficient write and coefficient read behaviour,
// over several register settings and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import nlms_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;

  typedef struct {
    kind_t                   kind;
    logic [3:0][SAMP_W-1:0]  anti;
    logic [3:0][SAMP_W-1:0]  err;
    logic [IDX_W-1:0]        idx;
    logic signed [COEF_W-1:0] val;
  } path_item_t;

  typedef struct {
    logic [3:0][SAMP_W-1:0] id_err;
    logic [COEF_W-1:0]      coef_rd;
  } path_result_t;

  // predictor of the identifier plus the queue of results it expects
  class path_scoreboard;
    bit [31:0]    step;
    bit [30:0]    pwr_floor;
    bit [2:0]     spk_cnt;
    bit [2:0]     mic_cnt;
    shortint      hist[NHIST];
    int unsigned  wr_ptr;
    int           coef[NCOEF];
    path_result_t pending_results[$];
    int           n_fail;

    function new();
      step = 0;
      pwr_floor = 1074;
      spk_cnt = 4;
      mic_cnt = 4;
      wr_ptr = 0;
      n_fail = 0;
      foreach (hist[i]) hist[i] = 0;
      foreach (coef[i]) coef[i] = 0;
    endfunction

    function void set_reg(reg_index_t r, bit [31:0] d);
      case (r)
        REG_STEP:     step = d;
        REG_FLOOR:    pwr_floor = d[30:0];
        REG_SPEAKERS: spk_cnt = d[2:0];
        default:      mic_cnt = d[2:0];
      endcase
    endfunction

    function int unsigned clamp_count(bit [2:0] v, int unsigned max);
      if (v == 0) return 1;
      return (v > max) ? max : v;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      n_fail++;
    endtask

    // work out the result of one accepted item and queue it
    function void note_item(path_item_t it);
      path_result_t     res;
      int unsigned      ns, nm, newest;
      longint unsigned  p, g;
      longint           gain[SPEAKERS];
      longint           acc, full, eq, eh, d, c;
      int               ci;
      res.id_err = '0;
      res.coef_rd = '0;
      case (it.kind)
        KIND_WRITE: if (it.idx < NCOEF) coef[it.idx] = int'(it.val);
        KIND_READ:  if (it.idx < NCOEF) res.coef_rd = coef[it.idx][COEF_W-1:0];
        KIND_SAMPLE: begin
          ns = clamp_count(spk_cnt, SPEAKERS);
          nm = clamp_count(mic_cnt, MICS);
          newest = wr_ptr % TAPS;
          for (int s = 0; s < ns; s++) hist[s*TAPS + newest] = $signed(it.anti[s]);
          wr_ptr = (newest + 1 == TAPS) ? 0 : newest + 1;
          // per speaker power and normalised gain
          for (int s = 0; s < ns; s++) begin
            p = pwr_floor;
            for (int k = 0; k < TAPS; k++)
              p += longint'(hist[s*TAPS + k]) * longint'(hist[s*TAPS + k]);
            if (p == 0) p = 1;
            g = (longint'(step) << 22) / p;
            gain[s] = (g > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : g;
          end
          for (int e = 0; e < nm; e++) begin
            acc = 0;
            for (int s = 0; s < ns; s++)
              for (int k = 0; k < TAPS; k++)
                acc += longint'(coef[(e*SPEAKERS + s)*TAPS + k]) *
                       longint'(hist[s*TAPS + (newest + TAPS - k) % TAPS]);
            full = longint'($signed(it.err[e])) * 4194304 - acc;
            eq = (full + 2097152) >>> 22;
            if (eq > 32767) eq = 32767;
            if (eq < -32768) eq = -32768;
            res.id_err[e] = eq[SAMP_W-1:0];
            // nlms tap update with saturation
            for (int s = 0; s < ns; s++)
              for (int k = 0; k < TAPS; k++) begin
                ci = (e*SPEAKERS + s)*TAPS + k;
                eh = eq * longint'(hist[s*TAPS + (newest + TAPS - k) % TAPS]);
                d = (eh * gain[s] + 64'sd2147483648) >>> 32;
                c = longint'(coef[ci]) + d;
                if (c > 8388607) c = 8388607;
                if (c < -8388608) c = -8388608;
                coef[ci] = int'(c);
              end
          end
        end
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    task check_result(path_result_t got);
      path_result_t exp;
      if (pending_results.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      exp = pending_results.pop_front();
      for (int e = 0; e < 4; e++)
        if (got.id_err[e] !== exp.id_err[e])
          report($sformatf("id_err_%0d got %0d exp %0d", e,
                 $signed(got.id_err[e]), $signed(exp.id_err[e])));
      if (got.coef_rd !== exp.coef_rd)
        report($sformatf("coef_read got %0d exp %0d",
               $signed(got.coef_rd), $signed(exp.coef_rd)));
    endtask
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] kind;
  logic signed [SAMP_W-1:0] anti_0, anti_1, anti_2, anti_3;
  logic signed [SAMP_W-1:0] err_0, err_1, err_2, err_3;
  logic [IDX_W-1:0] coef_index;
  logic signed [COEF_W-1:0] coef_value;
  logic out_valid, out_ready;
  logic signed [SAMP_W-1:0] id_err_0, id_err_1, id_err_2, id_err_3;
  logic signed [COEF_W-1:0] coef_read;

  path_scoreboard sb = new();
  int send_idle, recv_idle;
  int cycles;

  multichannel_nlms_path_identifier_unit u_dut (.*);

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("[multichannel_nlms_path_identifier_unit] ERROR");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  // result transfer check
  always @(posedge clk) begin
    path_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.id_err = {id_err_3, id_err_2, id_err_1, id_err_0};
      got.coef_rd = coef_read;
      sb.check_result(got);
    end
  end

  // entered and left at a falling edge
  task automatic send_item(path_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    kind <= it.kind;
    {anti_3, anti_2, anti_1, anti_0} <= it.anti;
    {err_3, err_2, err_1, err_0} <= it.err;
    coef_index <= it.idx;
    coef_value <= it.val;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t r, bit [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(r, d);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_all(bit [31:0] st, bit [31:0] fl, bit [2:0] ns, bit [2:0] nm);
    write_reg(REG_STEP, st);
    write_reg(REG_FLOOR, fl);
    write_reg(REG_SPEAKERS, 32'(ns));
    write_reg(REG_MICS, 32'(nm));
  endtask

  function automatic path_item_t make_item(kind_t k, logic [15:0] a, logic [15:0] e,
                                           logic [9:0] idx, logic [23:0] v);
    path_item_t it;
    it.kind = k;
    it.anti = {4{a}};
    it.err = {4{e}};
    it.idx = idx;
    it.val = v;
    return it;
  endfunction

  function automatic path_item_t rand_item();
    path_item_t it;
    int unsigned r;
    r = $urandom_range(99);
    it.kind = (r < 55) ? KIND_SAMPLE : (r < 78) ? KIND_WRITE : (r < 96) ? KIND_READ : KIND_NONE;
    for (int i = 0; i < 4; i++) begin
      it.anti[i] = SAMP_W'($urandom);
      it.err[i] = SAMP_W'($urandom);
    end
    // small drive levels keep some phases away from saturation
    if ($urandom_range(1)) for (int i = 0; i < 4; i++) it.anti[i] = $signed(it.anti[i]) >>> 6;
    it.idx = IDX_W'($urandom);
    it.val = COEF_W'($urandom);
    return it;
  endfunction

  task automatic random_phase(int n);
    repeat (n) send_item(rand_item());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_STEP;
    cfg_data = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    kind = KIND_SAMPLE;
    {anti_3, anti_2, anti_1, anti_0} = '0;
    {err_3, err_2, err_1, err_0} = '0;
    coef_index = '0;
    coef_value = '0;
    send_idle = 23;
    recv_idle = 52;
    cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero power with zero floor, gain saturates
    set_all(32'hFFFF_FFFF, 32'd0, 3'd4, 3'd4);
    send_item(make_item(KIND_SAMPLE, 16'h0000, 16'h7FFF, 10'd0, 24'd0));
    send_item(make_item(KIND_SAMPLE, 16'h0001, 16'h8000, 10'd0, 24'd0));
    drain();

    // directed extremes at reset settings
    set_all(32'd0, 32'd1074, 3'd4, 3'd4);
    send_item(make_item(KIND_WRITE, 16'd0, 16'd0, 10'd0, 24'h7FFFFF));
    send_item(make_item(KIND_WRITE, 16'd0, 16'd0, 10'd1023, 24'h800000));
    send_item(make_item(KIND_WRITE, 16'd0, 16'd0, 10'd64, 24'h400000));
    send_item(make_item(KIND_READ, 16'd0, 16'd0, 10'd0, 24'd0));
    send_item(make_item(KIND_READ, 16'd0, 16'd0, 10'd1023, 24'd0));
    send_item(make_item(KIND_READ, 16'd0, 16'd0, 10'd5, 24'd0));
    send_item(make_item(KIND_NONE, 16'hFFFF, 16'hFFFF, 10'h3FF, 24'hFFFFFF));
    send_item(make_item(KIND_SAMPLE, 16'h7FFF, 16'h8000, 10'd0, 24'd0));
    send_item(make_item(KIND_SAMPLE, 16'h8000, 16'h7FFF, 10'd0, 24'd0));
    send_item(make_item(KIND_SAMPLE, 16'hFFFF, 16'h0000, 10'd0, 24'd0));
    send_item(make_item(KIND_READ, 16'd0, 16'd0, 10'd0, 24'd0));
    drain();

    // adaptation at full scale with one speaker and one mic
    set_all(32'hFFFF_FFFF, 32'd0, 3'd1, 3'd1);
    send_item(make_item(KIND_SAMPLE, 16'h7FFF, 16'h7FFF, 10'd0, 24'd0));
    send_item(make_item(KIND_SAMPLE, 16'h8000, 16'h8000, 10'd0, 24'd0));
    send_item(make_item(KIND_READ, 16'd0, 16'd0, 10'd0, 24'd0));
    send_item(make_item(KIND_READ, 16'd0, 16'd0, 10'd1, 24'd0));
    drain();

    // random phases
    send_idle = 23;
    recv_idle = 52;
    set_all(32'h0010_0000, 32'd1074, 3'd4, 3'd4);
    random_phase(50);
    set_all(32'hFFFF_FFFF, 32'h4000_0000, 3'd1, 3'd1);
    random_phase(50);
    send_idle = 52;
    recv_idle = 23;
    set_all($urandom, $urandom, 3'd0, 3'd7);
    random_phase(50);
    set_all($urandom_range(32'h0100_0000), $urandom_range(32'h4000_0000), 3'd2, 3'd3);
    random_phase(50);
    send_idle = 0;
    recv_idle = 0;
    set_all(32'd0, 32'h7FFF_FFFF, 3'd5, 3'd0);
    random_phase(50);

    // trailing cycles, then verdict
    repeat (50) @(negedge clk);
    if (sb.pending_results.size() != 0) sb.report("results never arrived");
    if (sb.n_fail == 0) begin
      $display("[multichannel_nlms_path_identifier_unit] OK");
    end else begin
      $display("[multichannel_nlms_path_identifier_unit] ERROR");
    end
    $finish;
  end

endmodule
